// File: rtl/core/tardc_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and drive-mode helpers for the relay drive controller.
package tardc_pkg;

	localparam int CFG_INDEX_WIDTH = 4;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam int HYST_WIDTH      = 12;
	localparam int PAUSE_WIDTH     = 16;
	localparam int AZ_WIDTH        = 16;
	localparam int EL_WIDTH        = 15;
	localparam int NOW_WIDTH       = 32;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_AZ_HYST  = 4'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_EL_HYST  = 4'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_AZ_PAUSE = 4'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_EL_PAUSE = 4'd3;

	localparam logic [HYST_WIDTH-1:0]  HYST_RESET  = 12'd150;
	localparam logic [PAUSE_WIDTH-1:0] PAUSE_RESET = 16'd300;

	// Azimuth relay level wanted when demand lies below measurement;
	// elevation uses the opposite polarity.
	localparam logic AZ_WANT_BELOW = 1'b1;
	localparam logic EL_WANT_BELOW = 1'b0;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_AZ   = 2'd1,
		MODE_EL   = 2'd2,
		MODE_BOTH = 2'd3
	} mode_t;

	typedef struct packed {
		logic                 demand_ok;
		logic                 position_ok;
		logic [AZ_WIDTH-1:0]  target_az;
		logic [AZ_WIDTH-1:0]  measured_az;
		logic [EL_WIDTH-1:0]  target_el;
		logic [EL_WIDTH-1:0]  measured_el;
		logic [NOW_WIDTH-1:0] now_ms;
	} in_t;

	typedef struct packed {
		logic       az_direction;
		logic       el_direction;
		logic [1:0] drive_mode;
		logic       drive_restarted;
	} out_t;

	// Decision of one axis for the current tick.
	typedef struct packed {
		logic flip;
		logic relay_next;
		logic add;
		logic remove;
	} axis_act_t;

	typedef struct packed {
		mode_t mode;
		logic  restart;
	} drive_t;

	// Applies one axis decision to the drive mode.
	function automatic drive_t drive_apply(mode_t mode, mode_t axis, axis_act_t act);
		drive_t res;
		res.mode    = mode;
		res.restart = 1'b0;
		if (act.add) begin
			if ((mode & axis) == 2'b00) begin
				if (mode == MODE_OFF) begin
					res.mode = axis;
				end else begin
					res.mode    = MODE_BOTH;
					res.restart = 1'b1;
				end
			end
		end else if (act.remove) begin
			if ((mode & axis) != 2'b00) begin
				res.mode    = mode_t'(mode & ~axis);
				res.restart = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

// File: rtl/core/tardc_axis.sv
`timescale 1ns / 1ps
// Per-axis band test, relay pause check and relay/drive decision.
module tardc_axis #(
	parameter int POS_WIDTH  = 16,
	parameter int TIME_WIDTH = 32
) (
	input  logic [POS_WIDTH-1:0]              target,
	input  logic [POS_WIDTH-1:0]              measured,
	input  logic [tardc_pkg::HYST_WIDTH-1:0]  hyst,
	input  logic [tardc_pkg::PAUSE_WIDTH-1:0] pause,
	input  logic [TIME_WIDTH-1:0]             now,
	input  logic [TIME_WIDTH-1:0]             last_switch,
	input  logic                              relay,
	input  logic                              want_below,
	output tardc_pkg::axis_act_t              act
);
	import tardc_pkg::*;

	localparam int SUM_WIDTH = POS_WIDTH + 1;

	logic [SUM_WIDTH-1:0]  target_band;
	logic [SUM_WIDTH-1:0]  measured_band;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  below;
	logic                  above;
	logic                  pause_ok;
	logic                  move;
	logic                  want;

	assign target_band   = SUM_WIDTH'(target) + SUM_WIDTH'(hyst);
	assign measured_band = SUM_WIDTH'(measured) + SUM_WIDTH'(hyst);
	assign below         = target_band < SUM_WIDTH'(measured);
	assign above         = SUM_WIDTH'(target) > measured_band;

	// modular time difference, strict compare
	assign elapsed  = now - last_switch;
	assign pause_ok = elapsed > TIME_WIDTH'(pause);

	assign move = pause_ok && (below || above);
	assign want = below ? want_below : ~want_below;

	always_comb begin
		act.flip       = move && (relay != want);
		act.relay_next = move ? want : relay;
		act.add        = move && (relay == want);
		act.remove     = !move;
	end

endmodule

// File: rtl/core/two_axis_relay_drive_controller.sv
`timescale 1ns / 1ps
// Top level of the two-axis relay drive controller.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------
//  in       | in_valid / in_stall   | in_data  (tardc_pkg::in_t)
//  out      | out_valid / out_stall | out_data (tardc_pkg::out_t)
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One tick per clock while out_stall is low: a tick is registered on transfer,
// evaluated against the relay/mode registers once the output register is free,
// and then lands in the output register.
// Reset clears relays, mode, switch times and loads default bands and pauses.
// While a result waits under out_stall, one more tick is held; after that
// in_stall follows out_stall. cfg_ready is always high.
module two_axis_relay_drive_controller #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  tardc_pkg::in_t                        in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output tardc_pkg::out_t                       out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tardc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [tardc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import tardc_pkg::*;

	logic [HYST_WIDTH-1:0]  az_hyst_q;
	logic [HYST_WIDTH-1:0]  el_hyst_q;
	logic [PAUSE_WIDTH-1:0] az_pause_q;
	logic [PAUSE_WIDTH-1:0] el_pause_q;

	logic                  az_relay_q;
	logic                  el_relay_q;
	mode_t                 mode_q;
	logic [TIME_WIDTH-1:0] az_last_q;
	logic [TIME_WIDTH-1:0] el_last_q;

	logic valid_s1;
	in_t  item_s1;
	logic out_valid_q;
	out_t out_q;

	logic                  out_free;
	logic                  advance;
	logic                  accept;
	logic                  data_ok;
	logic [TIME_WIDTH-1:0] now_t;
	axis_act_t             az_act;
	axis_act_t             el_act;
	drive_t                az_drv;
	drive_t                el_drv;
	mode_t                 mode_next;
	logic                  restart;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_hyst_q  <= HYST_RESET;
			el_hyst_q  <= HYST_RESET;
			az_pause_q <= PAUSE_RESET;
			el_pause_q <= PAUSE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AZ_HYST:  az_hyst_q  <= cfg_data[HYST_WIDTH-1:0];
				REG_EL_HYST:  el_hyst_q  <= cfg_data[HYST_WIDTH-1:0];
				REG_AZ_PAUSE: az_pause_q <= cfg_data[PAUSE_WIDTH-1:0];
				REG_EL_PAUSE: el_pause_q <= cfg_data[PAUSE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign data_ok = item_s1.demand_ok && item_s1.position_ok;
	assign now_t   = TIME_WIDTH'(item_s1.now_ms);

	tardc_axis #(
		.POS_WIDTH  (AZ_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_az (
		.target      (item_s1.target_az),
		.measured    (item_s1.measured_az),
		.hyst        (az_hyst_q),
		.pause       (az_pause_q),
		.now         (now_t),
		.last_switch (az_last_q),
		.relay       (az_relay_q),
		.want_below  (AZ_WANT_BELOW),
		.act         (az_act)
	);

	tardc_axis #(
		.POS_WIDTH  (EL_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_el (
		.target      (item_s1.target_el),
		.measured    (item_s1.measured_el),
		.hyst        (el_hyst_q),
		.pause       (el_pause_q),
		.now         (now_t),
		.last_switch (el_last_q),
		.relay       (el_relay_q),
		.want_below  (EL_WANT_BELOW),
		.act         (el_act)
	);

	// elevation sees the mode left by the azimuth step
	always_comb begin
		az_drv = drive_apply(mode_q, MODE_AZ, az_act);
		el_drv = drive_apply(az_drv.mode, MODE_EL, el_act);
		if (data_ok) begin
			mode_next = el_drv.mode;
			restart   = az_drv.restart || el_drv.restart;
		end else begin
			mode_next = MODE_OFF;
			restart   = (mode_q != MODE_OFF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_relay_q  <= 1'b0;
			el_relay_q  <= 1'b0;
			mode_q      <= MODE_OFF;
			az_last_q   <= '0;
			el_last_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_next;
			out_valid_q <= 1'b1;
			if (data_ok) begin
				az_relay_q <= az_act.relay_next;
				el_relay_q <= el_act.relay_next;
				if (az_act.flip) begin
					az_last_q <= now_t;
				end
				if (el_act.flip) begin
					el_last_q <= now_t;
				end
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.az_direction    <= data_ok ? az_act.relay_next : az_relay_q;
			out_q.el_direction    <= data_ok ? el_act.relay_next : el_relay_q;
			out_q.drive_mode      <= mode_next;
			out_q.drive_restarted <= restart;
		end
	end

endmodule

// File: rtl/core/tardc_checker.sv
`timescale 1ns / 1ps
// Port-level checks on result transfers of the relay drive controller, with bind.
module tardc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input tardc_pkg::out_t out_data
);
	import tardc_pkg::*;

	logic       xfer;
	logic [1:0] last_mode_q;
	logic       last_az_q;
	logic       last_el_q;

	assign xfer = out_valid && !out_stall;

	// last delivered result, starting from the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mode_q <= MODE_OFF;
			last_az_q   <= 1'b0;
			last_el_q   <= 1'b0;
		end else if (xfer) begin
			last_mode_q <= out_data.drive_mode;
			last_az_q   <= out_data.az_direction;
			last_el_q   <= out_data.el_direction;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// without a restart the mode only stays or starts one axis from off
	a_quiet_mode: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !out_data.drive_restarted |->
			(out_data.drive_mode == last_mode_q) ||
			((last_mode_q == MODE_OFF) &&
			 (out_data.drive_mode == MODE_AZ || out_data.drive_mode == MODE_EL)))
		else $error("drive mode changed without restart");

	a_restart_change: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && out_data.drive_restarted |-> out_data.drive_mode != last_mode_q)
		else $error("restart flagged with unchanged mode");

	// a relay flip never changes that axis' drive bit in the same tick
	a_az_flip: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (out_data.az_direction != last_az_q) |->
			out_data.drive_mode[0] == last_mode_q[0])
		else $error("azimuth drive changed on relay flip");

	a_el_flip: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (out_data.el_direction != last_el_q) |->
			out_data.drive_mode[1] == last_mode_q[1])
		else $error("elevation drive changed on relay flip");

endmodule

bind two_axis_relay_drive_controller tardc_checker u_tardc_checker (.*);
